// ----- design/accumulator_machine_execute_unit_defines.svh -----
// assertion macros shared by the accumulator machine execute unit modules
// expects clk and rst_n in the scope of each use
`ifndef ACCUMULATOR_MACHINE_EXECUTE_UNIT_DEFINES_SVH
`define ACCUMULATOR_MACHINE_EXECUTE_UNIT_DEFINES_SVH

// checked only out of reset
`define ACCM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define ACCM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/accm_pkg.sv -----
// shared constants, opcodes, fault codes and interface structs
// for the accumulator machine execute unit; no dependencies
package accm_pkg;

  localparam int MEM_DEPTH   = 1024;
  localparam int ADDR_W      = $clog2(MEM_DEPTH);
  localparam int SP_W        = ADDR_W;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [3:0] OP_LOAD  = 4'd0;
  localparam logic [3:0] OP_STORE = 4'd1;
  localparam logic [3:0] OP_ADD   = 4'd2;
  localparam logic [3:0] OP_SUB   = 4'd3;
  localparam logic [3:0] OP_JMP   = 4'd4;
  localparam logic [3:0] OP_JPG   = 4'd5;
  localparam logic [3:0] OP_JPL   = 4'd6;
  localparam logic [3:0] OP_JPE   = 4'd7;
  localparam logic [3:0] OP_JPNE  = 4'd8;
  localparam logic [3:0] OP_PUSH  = 4'd9;
  localparam logic [3:0] OP_POP   = 4'd10;
  localparam logic [3:0] OP_CALL  = 4'd13;
  localparam logic [3:0] OP_RET   = 4'd14;

  localparam logic [1:0] FAULT_NONE  = 2'd0;
  localparam logic [1:0] FAULT_ADDR  = 2'd1;
  localparam logic [1:0] FAULT_OVER  = 2'd2;
  localparam logic [1:0] FAULT_UNDER = 2'd3;

  typedef enum logic [2:0] {
    CL_MEM,
    CL_JUMP,
    CL_PUSH,
    CL_POP,
    CL_CALL,
    CL_RET,
    CL_NOP
  } cls_t;

  typedef struct packed {
    cls_t               cls;
    logic [3:0]         opcode;
    logic signed [10:0] offset;
  } instr_t;

  // queue head toward the back end
  typedef struct packed {
    logic   valid;
    instr_t item;
  } fq_t;

  // back end control toward the front end
  typedef struct packed {
    logic pop;
    logic clearing;
  } bctl_t;

  function automatic cls_t classify(logic [3:0] op);
    cls_t c;
    case (op)
      OP_LOAD, OP_STORE, OP_ADD, OP_SUB:   c = CL_MEM;
      OP_JMP, OP_JPG, OP_JPL, OP_JPE, OP_JPNE: c = CL_JUMP;
      OP_PUSH: c = CL_PUSH;
      OP_POP:  c = CL_POP;
      OP_CALL: c = CL_CALL;
      OP_RET:  c = CL_RET;
      default: c = CL_NOP;
    endcase
    return c;
  endfunction

  function automatic logic [10:0] sp_view(logic [SP_W-1:0] sp);
    logic [31:0] w;
    w = 32'(sp);
    return w[10:0];
  endfunction

endpackage

// ----- design/accumulator_machine_execute_unit.sv -----
// top level of the accumulator machine execute unit
// depends on accm_pkg, accm_front and accm_back
//
//   channel  handshake             words
//   in       in_valid / in_stall   in_opcode, in_offset
//   out      out_valid / out_stall out_acc_value, out_prog_counter, out_stack_ptr, out_fault
//
// in the back end each instruction has an address state with the data memory read, then
// an execute and write back state; the registered read port of data memory sets this split
// after reset a clearing pass writes all MEM_DEPTH (1024) words of memory with all ones;
// in_stall is high during that pass
// reset is synchronous, active low
// out_stall holds the result register and the execute stage; the front queue
// keeps taking words until its 2 entries are full
module accumulator_machine_execute_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         in_opcode,
  input  logic signed [10:0] in_offset,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_acc_value,
  output logic signed [31:0] out_prog_counter,
  output logic [10:0]        out_stack_ptr,
  output logic [1:0]         out_fault
);
  import accm_pkg::*;

  fq_t   fq;
  bctl_t bctl;

  accm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_opcode (in_opcode),
    .in_offset (in_offset),
    .fq        (fq),
    .bctl      (bctl)
  );

  accm_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .fq               (fq),
    .bctl             (bctl),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_acc_value    (out_acc_value),
    .out_prog_counter (out_prog_counter),
    .out_stack_ptr    (out_stack_ptr),
    .out_fault        (out_fault)
  );

endmodule

// ----- design/accm_ram.sv -----
// generic single write port, single read port ram with registered read
// no dependencies
module accm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// ----- design/accm_front.sv -----
// front end: takes instruction words, classifies the opcode, queues them
// depends on accm_pkg and the assertion macro header
`include "accumulator_machine_execute_unit_defines.svh"

module accm_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         in_opcode,
  input  logic signed [10:0] in_offset,
  output accm_pkg::fq_t      fq,
  input  accm_pkg::bctl_t    bctl
);
  import accm_pkg::*;

  instr_t              q_mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                push;
  logic                pop;
  instr_t              new_item;

  function automatic logic [QPTR_W-1:0] ptr_inc(logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign in_stall = bctl.clearing || (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign pop      = bctl.pop;

  always_comb begin
    new_item.cls    = classify(in_opcode);
    new_item.opcode = in_opcode;
    new_item.offset = in_offset;
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= new_item;
    end
  end

  assign fq.valid = (cnt_r != '0);
  assign fq.item  = q_mem_r[rd_ptr_r];

  `ACCM_ASSERT(a_cnt_range, cnt_r <= QCNT_W'(QUEUE_DEPTH), "queue count beyond depth")
  `ACCM_ASSERT(a_pop_nonempty, pop |-> (cnt_r != '0), "pop from empty queue")
  `ACCM_ASSERT(a_cnt_grow, (push && !pop) |=> (cnt_r == $past(cnt_r) + 1'b1), "queue count lost a word")

endmodule

// ----- design/accm_back.sv -----
// back end: address and memory read, then execute and write back
// depends on accm_pkg, accm_ram and the assertion macro header
`include "accumulator_machine_execute_unit_defines.svh"

module accm_back (
  input  logic               clk,
  input  logic               rst_n,
  input  accm_pkg::fq_t      fq,
  output accm_pkg::bctl_t    bctl,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_acc_value,
  output logic signed [31:0] out_prog_counter,
  output logic [10:0]        out_stack_ptr,
  output logic [1:0]         out_fault
);
  import accm_pkg::*;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_ADDR,
    S_EXEC
  } state_t;

  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [31:0]       acc_r, acc_nxt;
  logic [31:0]       pc_r, pc_nxt;
  logic [SP_W-1:0]   sp_r, sp_nxt;
  instr_t            item_r;
  logic [31:0]       ea_r, ea_nxt;
  logic              ea_ok_r, ea_ok_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [31:0]       out_acc_r;
  logic [31:0]       out_pc_r;
  logic [10:0]       out_sp_r;
  logic [1:0]        out_fault_r;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [31:0]       ram_wdata, ram_rdata;

  logic              out_free;
  logic              exec_fire;
  logic              data_exec;
  logic [1:0]        fault_nxt;
  logic              ex_we;
  logic [ADDR_W-1:0] ex_waddr;
  logic [31:0]       ex_wdata;
  logic [SP_W-1:0]   sp_dec, sp_inc;
  logic              sp_zero, sp_empty;
  logic              take_jump;

  assign out_free  = !out_valid_r || !out_stall;
  assign exec_fire = (state_r == S_EXEC) && out_free;
  assign data_exec = exec_fire && (item_r.cls inside {CL_MEM, CL_PUSH, CL_POP});

  assign bctl.pop      = (state_r == S_ADDR) && fq.valid;
  assign bctl.clearing = (state_r == S_CLEAR);

  // address stage; the read address holds while execute waits
  always_comb begin
    ea_nxt    = pc_r + {{21{fq.item.offset[10]}}, fq.item.offset};
    ea_ok_nxt = ea_nxt < 32'(MEM_DEPTH);
    if (state_r == S_EXEC) begin
      if (item_r.cls inside {CL_POP, CL_RET}) begin
        ram_raddr = sp_r;
      end else begin
        ram_raddr = ea_r[ADDR_W-1:0];
      end
    end else if (fq.item.cls == CL_POP || fq.item.cls == CL_RET) begin
      ram_raddr = sp_r;
    end else begin
      ram_raddr = ea_nxt[ADDR_W-1:0];
    end
  end

  // execute stage
  always_comb begin
    sp_dec    = sp_r - 1'b1;
    sp_inc    = sp_r + 1'b1;
    sp_zero   = (sp_r == '0);
    sp_empty  = (sp_r >= SP_W'(MEM_DEPTH - 1));
    acc_nxt   = acc_r;
    pc_nxt    = pc_r;
    sp_nxt    = sp_r;
    fault_nxt = FAULT_NONE;
    ex_we     = 1'b0;
    ex_waddr  = ea_r[ADDR_W-1:0];
    ex_wdata  = acc_r;
    take_jump = 1'b0;
    case (item_r.cls)
      CL_MEM: begin
        if (!ea_ok_r) begin
          fault_nxt = FAULT_ADDR;
        end else begin
          case (item_r.opcode)
            OP_LOAD:  acc_nxt = ram_rdata;
            OP_STORE: ex_we = 1'b1;
            OP_ADD:   acc_nxt = acc_r + ram_rdata;
            OP_SUB:   acc_nxt = acc_r - ram_rdata;
            default:  acc_nxt = acc_r;
          endcase
        end
      end
      CL_JUMP: begin
        case (item_r.opcode)
          OP_JMP:  take_jump = 1'b1;
          OP_JPG:  take_jump = (acc_r != '0) && !acc_r[31];
          OP_JPL:  take_jump = acc_r[31];
          OP_JPE:  take_jump = (acc_r == '0);
          OP_JPNE: take_jump = (acc_r != '0);
          default: take_jump = 1'b0;
        endcase
        if (take_jump) begin
          pc_nxt = ea_r;
        end
      end
      CL_PUSH: begin
        if (!ea_ok_r) begin
          fault_nxt = FAULT_ADDR;
        end else if (sp_zero) begin
          fault_nxt = FAULT_OVER;
        end else begin
          sp_nxt   = sp_dec;
          ex_we    = 1'b1;
          ex_waddr = sp_dec;
          ex_wdata = ram_rdata;
        end
      end
      CL_POP: begin
        if (!ea_ok_r) begin
          fault_nxt = FAULT_ADDR;
        end else if (sp_empty) begin
          fault_nxt = FAULT_UNDER;
        end else begin
          sp_nxt   = sp_inc;
          ex_we    = 1'b1;
          ex_wdata = ram_rdata;
        end
      end
      CL_CALL: begin
        if (sp_zero) begin
          fault_nxt = FAULT_OVER;
        end else begin
          sp_nxt   = sp_dec;
          ex_we    = 1'b1;
          ex_waddr = sp_dec;
          ex_wdata = pc_r;
          pc_nxt   = ea_r;
        end
      end
      CL_RET: begin
        if (sp_empty) begin
          fault_nxt = FAULT_UNDER;
        end else begin
          pc_nxt = ram_rdata;
          sp_nxt = sp_inc;
        end
      end
      default: fault_nxt = FAULT_NONE;
    endcase
  end

  // memory write port: clearing pass or execute write back
  always_comb begin
    if (state_r == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_r;
      ram_wdata = '1;
    end else begin
      ram_we    = exec_fire && ex_we;
      ram_waddr = ex_waddr;
      ram_wdata = ex_wdata;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    case (state_r)
      S_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == ADDR_W'(MEM_DEPTH - 1)) begin
          state_nxt = S_ADDR;
        end
      end
      S_ADDR: begin
        if (fq.valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          state_nxt = S_ADDR;
        end
      end
      default: state_nxt = S_ADDR;
    endcase
    out_valid_nxt = exec_fire || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      acc_r       <= '0;
      pc_r        <= '0;
      sp_r        <= SP_W'(MEM_DEPTH - 1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (bctl.pop) begin
        item_r  <= fq.item;
        ea_r    <= ea_nxt;
        ea_ok_r <= ea_ok_nxt;
      end
      if (exec_fire) begin
        acc_r       <= acc_nxt;
        pc_r        <= pc_nxt;
        sp_r        <= sp_nxt;
        out_acc_r   <= acc_nxt;
        out_pc_r    <= pc_nxt;
        out_sp_r    <= sp_view(sp_nxt);
        out_fault_r <= fault_nxt;
      end
    end
  end

  accm_ram #(
    .WIDTH (32),
    .DEPTH (MEM_DEPTH)
  ) u_dmem (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_valid        = out_valid_r;
  assign out_acc_value    = out_acc_r;
  assign out_prog_counter = out_pc_r;
  assign out_stack_ptr    = out_sp_r;
  assign out_fault        = out_fault_r;

  `ACCM_ASSERT(a_sp_range, sp_r <= SP_W'(MEM_DEPTH - 1), "stack pointer out of range")
  `ACCM_ASSERT_ALWAYS(a_no_pop_clear, bctl.clearing |-> !bctl.pop, "queue popped during clear")
  `ACCM_ASSERT(a_pc_hold, data_exec |=> $stable(pc_r), "pc moved on a data op")
  `ACCM_ASSERT(a_result_src, $rose(out_valid_r) |-> ($past(state_r) == S_EXEC), "no execute")

endmodule
